// File: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'h55;
  localparam logic [7:0] MinLength = 8'd43;

  localparam int ByteW    = 8;
  localparam int WordW    = 16;
  localparam int ValueW   = 17;
  localparam int IdxW     = 4;
  localparam int CapDepth = 32;
  localparam int OrgDepth = 4;
  localparam int CapAddrW = $clog2(CapDepth);
  localparam int OrgAddrW = $clog2(OrgDepth);

  localparam logic [IdxW-1:0] OdomFirst = 4'd7;
  localparam logic [IdxW-1:0] OdomLast  = 4'd9;
  localparam logic [IdxW-1:0] LastField = 4'd13;

  typedef enum logic [3:0] {
    PhSeekFirst  = 4'b0001,
    PhSeekSecond = 4'b0010,
    PhLength     = 4'b0100,
    PhBody       = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    StField  = 2'd0,
    StBadSum = 2'd1,
    StShort  = 2'd2
  } status_e;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } slot_t;

  // word slot for a frame position; only meaningful on the low byte of a word
  function automatic slot_t word_slot(input logic [ByteW-1:0] pos);
    slot_t s;
    logic [ByteW-1:0] off;
    s.hit = 1'b0;
    s.idx = '0;
    off   = '0;
    if (pos >= 8'd4 && pos <= 8'd15) begin
      off   = pos - 8'd4;
      s.hit = 1'b1;
      s.idx = IdxW'(off >> 1);
    end else if (pos >= 8'd20 && pos <= 8'd27) begin
      off   = pos - 8'd20;
      s.hit = 1'b1;
      s.idx = IdxW'(off >> 1) + 4'd6;
    end else if (pos >= 8'd34 && pos <= 8'd41) begin
      off   = pos - 8'd34;
      s.hit = 1'b1;
      s.idx = IdxW'(off >> 1) + 4'd10;
    end
    return s;
  endfunction

endpackage

// File: rtl/sfd_ram.sv
module sfd_ram #(
  parameter int Width = 16,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sensor_frame_deframer.sv
// sensor frame deframer
// rx channel: one received serial byte per item (rx_valid_i / rx_stall_o).
// frames are 0xAA 0x55, a total-length byte, the body and an additive
// checksum byte. out channel (out_valid_o / out_stall_i) carries results:
// a run of 14 signed fields for a good frame (last_o on field 13), or one
// error item for a bad checksum or a length byte below 43.
// bytes are taken one per cycle while rx_stall_o is low. the 14 fields are
// captured as words into a two-bank capture ram, so the next frame fills one
// bank while the previous run is read out of the other, one field per cycle
// while out_stall_i is low. after the checksum (or short length) byte is
// accepted, results pass through the job, s1 and output registers.
// a short length or checksum byte is stalled while an earlier run is still
// being read from the ram; with out_stall_i low and frames of 43 bytes or
// more the byte stream never stalls.
// odometry fields are given relative to an origin held in a small ram,
// written from each frame's words until a frame passes its checksum.
// reset returns to the header hunt and forgets the origin; no clearing pass.
// while out_stall_i is high the output item holds and the read-out pauses.
module sensor_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rx_valid_i,
  output logic                               rx_stall_o,
  input  logic [7:0]                         rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [3:0]                         field_index_o,
  output logic signed [sfd_pkg::ValueW-1:0]  value_o,
  output logic                               last_o
);
  import sfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [ByteW-1:0] pos_q, pos_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] hi_q;
  logic             wr_bank_q, wr_bank_d;
  logic             org_valid_q, org_valid_d;

  logic             job_active_q, job_active_d;
  status_e          job_status_q, job_status_d;
  logic             job_bank_q, job_bank_d;
  logic [IdxW-1:0]  job_idx_q, job_idx_d;

  logic             s1_valid_q, s1_valid_d;
  status_e          s1_status_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic             s1_last_q;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  logic [IdxW-1:0]          out_idx_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_last_q;

  logic             body_more, job_byte, rx_fire;
  logic             job_start;
  status_e          job_start_status;
  slot_t            slot;

  logic                cap_we, org_we;
  logic [CapAddrW-1:0] cap_waddr, cap_raddr;
  logic [OrgAddrW-1:0] org_waddr, org_raddr;
  logic [WordW-1:0]    cap_wdata, cap_rdata, org_rdata;
  logic                cap_re;

  logic             out_free, issue, is_odom;
  logic signed [ValueW-1:0] word_ext, org_ext, field_value;

  // frame parser
  assign body_more  = ({1'b0, pos_q} + 9'd1) < {1'b0, len_q};
  // only bytes that would start a new job wait for the read-out
  assign job_byte   = ((phase_q == PhLength) && (rx_byte_i < MinLength)) ||
                      ((phase_q == PhBody) && !body_more);
  assign rx_stall_o = job_byte && job_active_q;
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  always_comb begin
    phase_d          = phase_q;
    pos_d            = pos_q;
    len_d            = len_q;
    sum_d            = sum_q;
    wr_bank_d        = wr_bank_q;
    org_valid_d      = org_valid_q;
    job_start        = 1'b0;
    job_start_status = StField;
    unique case (phase_q)
      PhSeekFirst: begin
        if (rx_fire && rx_byte_i == HdrFirst) begin
          phase_d = PhSeekSecond;
        end
      end
      PhSeekSecond: begin
        if (rx_fire) begin
          phase_d = (rx_byte_i == HdrSecond) ? PhLength : PhSeekFirst;
        end
      end
      PhLength: begin
        if (rx_fire) begin
          if (rx_byte_i < MinLength) begin
            job_start        = 1'b1;
            job_start_status = StShort;
            phase_d          = PhSeekFirst;
          end else begin
            len_d   = rx_byte_i;
            sum_d   = ByteW'(HdrFirst + HdrSecond + rx_byte_i);
            pos_d   = 8'd3;
            phase_d = PhBody;
          end
        end
      end
      PhBody: begin
        if (rx_fire) begin
          if (body_more) begin
            sum_d = ByteW'(sum_q + rx_byte_i);
            pos_d = ByteW'(pos_q + 8'd1);
          end else begin
            phase_d   = PhSeekFirst;
            pos_d     = '0;
            job_start = 1'b1;
            if (rx_byte_i != sum_q) begin
              job_start_status = StBadSum;
            end else begin
              job_start_status = StField;
              wr_bank_d        = !wr_bank_q;
              org_valid_d      = 1'b1;
            end
          end
        end
      end
      default: begin
        phase_d = PhSeekFirst;
      end
    endcase
  end

  // capture writes: a word goes in on its low byte
  assign slot      = word_slot(pos_q);
  assign cap_we    = rx_fire && (phase_q == PhBody) && body_more && pos_q[0] && slot.hit;
  assign cap_waddr = {wr_bank_q, slot.idx};
  assign cap_wdata = {hi_q, rx_byte_i};
  assign org_we    = cap_we && !org_valid_q && (slot.idx >= OdomFirst) && (slot.idx <= OdomLast);
  assign org_waddr = OrgAddrW'(slot.idx - OdomFirst);

  // read-out: writer and reader always sit in different banks, and the
  // origin is no longer written once any run can read it
  assign out_free  = !out_valid_q || !out_stall_i;
  assign issue     = job_active_q && (!s1_valid_q || out_free);
  assign cap_re    = issue && (job_status_q == StField);
  assign cap_raddr = {job_bank_q, job_idx_q};
  assign org_raddr = OrgAddrW'(job_idx_q - OdomFirst);

  always_comb begin
    job_active_d = job_active_q;
    job_status_d = job_status_q;
    job_bank_d   = job_bank_q;
    job_idx_d    = job_idx_q;
    s1_valid_d   = s1_valid_q;
    if (job_start) begin
      job_active_d = 1'b1;
      job_status_d = job_start_status;
      job_bank_d   = wr_bank_q;
      job_idx_d    = '0;
    end else if (issue) begin
      job_idx_d = IdxW'(job_idx_q + 4'd1);
      if (job_status_q != StField || job_idx_q == LastField) begin
        job_active_d = 1'b0;
      end
    end
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  assign is_odom     = (s1_idx_q >= OdomFirst) && (s1_idx_q <= OdomLast);
  assign word_ext    = {cap_rdata[WordW-1], cap_rdata};
  assign org_ext     = is_odom ? {org_rdata[WordW-1], org_rdata} : '0;
  assign field_value = (s1_status_q == StField) ? (word_ext - org_ext) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSeekFirst;
      pos_q        <= '0;
      len_q        <= '0;
      sum_q        <= '0;
      wr_bank_q    <= 1'b0;
      org_valid_q  <= 1'b0;
      job_active_q <= 1'b0;
      job_status_q <= StField;
      job_bank_q   <= 1'b0;
      job_idx_q    <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
      sum_q        <= sum_d;
      wr_bank_q    <= wr_bank_d;
      org_valid_q  <= org_valid_d;
      job_active_q <= job_active_d;
      job_status_q <= job_status_d;
      job_bank_q   <= job_bank_d;
      job_idx_q    <= job_idx_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && phase_q == PhBody && !pos_q[0]) begin
      hi_q <= rx_byte_i;
    end
    if (issue) begin
      s1_status_q <= job_status_q;
      s1_idx_q    <= (job_status_q == StField) ? job_idx_q : '0;
      s1_last_q   <= (job_status_q != StField) || (job_idx_q == LastField);
    end
    if (out_free && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_idx_q    <= s1_idx_q;
      out_value_q  <= field_value;
      out_last_q   <= s1_last_q;
    end
  end

  sfd_ram #(
    .Width(WordW),
    .Depth(CapDepth)
  ) u_cap_ram (
    .clk_i  (clk_i),
    .we_i   (cap_we),
    .waddr_i(cap_waddr),
    .wdata_i(cap_wdata),
    .re_i   (cap_re),
    .raddr_i(cap_raddr),
    .rdata_o(cap_rdata)
  );

  sfd_ram #(
    .Width(WordW),
    .Depth(OrgDepth)
  ) u_org_ram (
    .clk_i  (clk_i),
    .we_i   (org_we),
    .waddr_i(org_waddr),
    .wdata_i(cap_wdata),
    .re_i   (cap_re),
    .raddr_i(org_raddr),
    .rdata_o(org_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign field_index_o = out_idx_q;
  assign value_o       = out_value_q;
  assign last_o        = out_last_q;

endmodule

// File: test/sensor_frame_deframer_test.sv
module sensor_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  typedef enum int {
    FillRandom,
    FillZero,
    FillOnes,
    FillMaxPos,
    FillMinNeg
  } fill_e;

  typedef struct {
    status_e          st;
    logic [IdxW-1:0]  idx;
    logic [ValueW-1:0] val;
    logic             lst;
  } result_t;

  class frame_tracker;
    result_t    awaited[$];
    int         errors;
    int         n_checked;
    int         n_good;
    int         n_badsum;
    int         n_short;
    phase_e     hunt;
    logic [7:0] pos;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] cap[28];
    bit         org_valid;
    logic [15:0] org[3];

    function new();
      errors    = 0;
      n_checked = 0;
      n_good    = 0;
      n_badsum  = 0;
      n_short   = 0;
      hunt      = PhSeekFirst;
      pos       = '0;
      len       = '0;
      sum       = '0;
      org_valid = 1'b0;
    endfunction

    function void push_error(status_e st);
      result_t r;
      r.st  = st;
      r.idx = '0;
      r.val = '0;
      r.lst = 1'b1;
      awaited.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      result_t     r;
      int          v;
      logic [15:0] w;
      case (hunt)
        PhSeekFirst: begin
          if (b == HdrFirst) hunt = PhSeekSecond;
        end
        PhSeekSecond: begin
          // a wrong second byte is dropped, not retried as a first byte
          if (b == HdrSecond) hunt = PhLength;
          else hunt = PhSeekFirst;
        end
        PhLength: begin
          if (b < MinLength) begin
            hunt = PhSeekFirst;
            push_error(StShort);
            n_short++;
          end else begin
            len  = b;
            sum  = HdrFirst + HdrSecond + b;
            pos  = 8'd3;
            hunt = PhBody;
          end
        end
        default: begin
          if (int'(pos) + 1 < int'(len)) begin
            if (pos >= 8'd4 && pos <= 8'd15) cap[pos - 8'd4] = b;
            else if (pos >= 8'd20 && pos <= 8'd27) cap[pos - 8'd8] = b;
            else if (pos >= 8'd34 && pos <= 8'd41) cap[pos - 8'd14] = b;
            sum = sum + b;
            pos = pos + 8'd1;
          end else begin
            hunt = PhSeekFirst;
            pos  = '0;
            if (b != sum) begin
              push_error(StBadSum);
              n_badsum++;
            end else begin
              // origin comes from the first frame that passes its checksum
              if (!org_valid) begin
                for (int k = 0; k < 3; k++) org[k] = {cap[14 + 2 * k], cap[15 + 2 * k]};
                org_valid = 1'b1;
              end
              for (int i = 0; i < 14; i++) begin
                w = {cap[2 * i], cap[2 * i + 1]};
                v = int'($signed(w));
                if (i >= 7 && i <= 9) v = v - int'($signed(org[i - 7]));
                r.st  = StField;
                r.idx = i[IdxW-1:0];
                r.val = v[ValueW-1:0];
                r.lst = (i == 13);
                awaited.push_back(r);
              end
              n_good++;
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [IdxW-1:0] idx, logic [ValueW-1:0] val,
                               logic lst);
      result_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d field %0d value %0d",
               st, idx, $signed(val));
        errors++;
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("field_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (val !== e.val) begin
        $error("value: expected %0d, got %0d", $signed(e.val), $signed(val));
        errors++;
      end
      if (lst !== e.lst) begin
        $error("last: expected %0d, got %0d", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     rx_valid_i;
  logic                     rx_stall_o;
  logic [7:0]               rx_byte_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [3:0]               field_index_o;
  logic signed [ValueW-1:0] value_o;
  logic                     last_o;

  frame_tracker trk;
  int src_idle_pct;
  int sink_stall_pct;
  int bytes_sent;
  int framed_bytes;

  sensor_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // output side: check what was taken at this edge, then pick the next stall
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
        trk.check_result(status_o, field_index_o, value_o, last_o);
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o !== 1'b0) @(posedge clk_i);
    trk.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_short(input logic [7:0] len);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(len);
    framed_bytes += 3;
  endtask

  task automatic send_frame(input int len, input bit bad_sum, input fill_e fill);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] b;
    fb.push_back(HdrFirst);
    fb.push_back(HdrSecond);
    fb.push_back(len[7:0]);
    sum = HdrFirst + HdrSecond + len[7:0];
    for (int p = 3; p < len - 1; p++) begin
      case (fill)
        FillZero:   b = 8'h00;
        FillOnes:   b = 8'hFF;
        FillMaxPos: b = p[0] ? 8'hFF : 8'h7F;
        FillMinNeg: b = p[0] ? 8'h00 : 8'h80;
        default:    b = 8'($urandom);
      endcase
      fb.push_back(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    fb.push_back(sum);
    foreach (fb[k]) send_byte(fb[k]);
    framed_bytes += len;
  endtask

  task automatic random_item();
    int         r;
    int         len;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 65) begin
      if ($urandom_range(99) < 90) len = $urandom_range(48, 43);
      else len = $urandom_range(60, 49);
      send_frame(len, 1'b0, FillRandom);
    end else if (r < 78) begin
      send_frame($urandom_range(50, 43), 1'b1, FillRandom);
    end else if (r < 88) begin
      send_short(8'($urandom_range(42, 0)));
    end else if (r < 94) begin
      b = 8'($urandom);
      if (b == HdrSecond) b = ~b;
      send_byte(HdrFirst);
      send_byte(b);
    end else begin
      // line noise, kept clear of a first header byte
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom);
        if (b == HdrFirst) b = 8'h00;
        send_byte(b);
      end
    end
  endtask

  initial begin
    int src_tab[4];
    int sink_tab[4];
    int start;
    src_tab  = '{0, 65, 0, 37};
    sink_tab = '{0, 0, 65, 37};
    trk = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    framed_bytes   = 0;
    rst_ni     = 1'b0;
    rx_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(HdrSecond);
    send_byte(8'hFF);
    // second header byte wrong: dropped, then the stray 0x55 is ignored
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_short(8'd0);
    // origin at the top of the range, so a later negative frame lands one above the floor
    send_frame(43, 1'b0, FillMaxPos);
    // short length right behind a run: held off until the run is read out
    send_short(MinLength - 8'd1);
    send_frame(43, 1'b1, FillMaxPos);
    send_frame(43, 1'b0, FillMinNeg);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_tab[ph];
      sink_stall_pct = sink_tab[ph];
      start = framed_bytes;
      while (framed_bytes - start < 30) random_item();
    end
    rx_valid_i <= 1'b0;

    while (trk.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes; checked %0d results", bytes_sent, trk.n_checked);
    $display("%0d good frames, %0d checksum drops, %0d short lengths",
             trk.n_good, trk.n_badsum, trk.n_short);
    if (trk.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/sensor_frame_deframer.sv
test/sensor_frame_deframer_test.sv
